// File: hdl/fsd_pkg.sv
package fsd_pkg;

   localparam int FSD_DIGITS      = 4;
   localparam int FSD_SEGMENTS    = 7;
   localparam int FSD_QUEUE_DEPTH = 2;

   localparam int DIGIT_W = 4;
   localparam int POS_W   = 2;
   localparam int SEG_W   = 3;
   localparam int POS_MAX = 4;

   // Reciprocal constants for division by ten.
   // The wide one is exact over 16 bits; the narrow one is exact over 7 bits.
   localparam logic [15:0] RECIP10_WIDE        = 16'hCCCD;
   localparam int          RECIP10_WIDE_SHIFT  = 19;
   localparam logic [7:0]  RECIP10_NARROW      = 8'd205;
   localparam int          RECIP10_NARROW_SHIFT = 11;

   localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;
   localparam logic [DIGIT_W-1:0] DIGIT_BASE = 4'd10;

   localparam logic [POS_W-1:0] POS_TIME_LAST = 2'd3;

   localparam logic [3:0] POLARITY_RESET = 4'd8;

   typedef struct packed {
      logic        req_type;
      logic [15:0] number_value;
      logic [6:0]  hours;
      logic [6:0]  minutes;
   } req_word_type;

   typedef struct packed {
      logic [POS_W-1:0] digit_select;
      logic [SEG_W-1:0] segment_select;
      logic             drive_level;
      logic             last_pulse;
   } rsp_word_type;

   // One converted request: digits in the order they are sent, and the
   // position of the first digit sent (positions count down from it to zero).
   typedef struct packed {
      logic [POS_MAX-1:0][DIGIT_W-1:0] digits;
      logic [POS_W-1:0]                last_idx;
   } fsd_entry_type;

   function automatic logic [FSD_SEGMENTS-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
      logic [FSD_SEGMENTS-1:0] p;
      begin
         case (d)
            4'd0:    p = 7'b0111111;
            4'd1:    p = 7'b0110000;
            4'd2:    p = 7'b1011011;
            4'd3:    p = 7'b1111001;
            4'd4:    p = 7'b1110100;
            4'd5:    p = 7'b1101101;
            4'd6:    p = 7'b1101111;
            4'd7:    p = 7'b0111000;
            4'd8:    p = 7'b1111111;
            4'd9:    p = 7'b1111101;
            default: p = 7'b1111101;
         endcase
         return p;
      end
   endfunction

   function automatic logic [DIGIT_W-1:0] sat_digit(input logic [DIGIT_W-1:0] d);
      begin
         return (d > MAX_DIGIT) ? MAX_DIGIT : d;
      end
   endfunction

endpackage

// File: hdl/fsd_front.sv
module fsd_front #(
   parameter int DIGITS = fsd_pkg::FSD_DIGITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fsd_pkg::req_word_type req_word,
   output logic                  push_valid,
   input  logic                  push_ready,
   output fsd_pkg::fsd_entry_type push_entry
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_PUSH = 3'b100
   } front_state_type;

   localparam logic [fsd_pkg::POS_W-1:0] LAST_NUM_IDX = fsd_pkg::POS_W'(DIGITS - 1);

   front_state_type state_ff, state_in;
   logic [fsd_pkg::POS_W-1:0] cnt_ff, cnt_in;
   logic        mode_ff, mode_in;
   logic [15:0] rem_ff, rem_in;
   logic [6:0]  hours_ff, hours_in;
   logic [6:0]  minutes_ff, minutes_in;
   fsd_pkg::fsd_entry_type entry_ff, entry_in;

   logic        accept;
   logic [31:0] wide_prod;
   logic [12:0] wide_q;
   logic [15:0] wide_r;
   logic [14:0] hours_prod;
   logic [14:0] minutes_prod;
   logic [fsd_pkg::DIGIT_W-1:0] hours_q;
   logic [fsd_pkg::DIGIT_W-1:0] minutes_q;
   logic [6:0]  hours_r;
   logic [6:0]  minutes_r;

   assign req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_PUSH) && push_ready));
   assign accept     = req_valid && !req_stall;
   assign push_valid = (state_ff == ST_PUSH);
   assign push_entry = entry_ff;

   // One decimal digit per cycle: quotient by reciprocal, remainder by multiply-subtract.
   assign wide_prod = rem_ff * fsd_pkg::RECIP10_WIDE;
   assign wide_q    = wide_prod[31:fsd_pkg::RECIP10_WIDE_SHIFT];
   assign wide_r    = rem_ff - ({3'b000, wide_q} * 16'(fsd_pkg::DIGIT_BASE));

   assign hours_prod   = hours_ff * fsd_pkg::RECIP10_NARROW;
   assign minutes_prod = minutes_ff * fsd_pkg::RECIP10_NARROW;
   assign hours_q      = hours_prod[14:fsd_pkg::RECIP10_NARROW_SHIFT];
   assign minutes_q    = minutes_prod[14:fsd_pkg::RECIP10_NARROW_SHIFT];
   assign hours_r      = hours_ff - ({3'b000, hours_q} * 7'(fsd_pkg::DIGIT_BASE));
   assign minutes_r    = minutes_ff - ({3'b000, minutes_q} * 7'(fsd_pkg::DIGIT_BASE));

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      mode_in    = mode_ff;
      rem_in     = rem_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      entry_in   = entry_ff;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_CONV: begin
            if (mode_ff) begin
               entry_in.digits[0] = fsd_pkg::sat_digit(hours_q);
               entry_in.digits[1] = hours_r[fsd_pkg::DIGIT_W-1:0];
               entry_in.digits[2] = fsd_pkg::sat_digit(minutes_q);
               entry_in.digits[3] = minutes_r[fsd_pkg::DIGIT_W-1:0];
               entry_in.last_idx  = fsd_pkg::POS_TIME_LAST;
               state_in           = ST_PUSH;
            end else begin
               entry_in.digits[cnt_ff] = wide_r[fsd_pkg::DIGIT_W-1:0];
               entry_in.last_idx       = LAST_NUM_IDX;
               rem_in                  = {3'b000, wide_q};
               if (cnt_ff == LAST_NUM_IDX) begin
                  state_in = ST_PUSH;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (accept) begin
         state_in   = ST_CONV;
         cnt_in     = '0;
         mode_in    = req_word.req_type;
         rem_in     = req_word.number_value;
         hours_in   = req_word.hours;
         minutes_in = req_word.minutes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      mode_ff    <= mode_in;
      rem_ff     <= rem_in;
      hours_ff   <= hours_in;
      minutes_ff <= minutes_in;
      entry_ff   <= entry_in;
   end

endmodule

// File: hdl/fsd_queue.sv
module fsd_queue #(
   parameter int DEPTH = fsd_pkg::FSD_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  fsd_pkg::fsd_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output fsd_pkg::fsd_entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   fsd_pkg::fsd_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count exceeds depth");
`endif

endmodule

// File: hdl/fsd_back.sv
module fsd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [3:0]             polarity,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  fsd_pkg::fsd_entry_type pop_entry,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fsd_pkg::rsp_word_type  rsp_word
);

   localparam logic [fsd_pkg::SEG_W-1:0] SEG_LAST = fsd_pkg::SEG_W'(fsd_pkg::FSD_SEGMENTS - 1);

   logic active_ff, active_in;
   fsd_pkg::fsd_entry_type cur_ff, cur_in;
   logic [fsd_pkg::POS_W-1:0] dig_ff, dig_in;
   logic [fsd_pkg::SEG_W-1:0] seg_ff, seg_in;
   logic out_valid_ff, out_valid_in;
   fsd_pkg::rsp_word_type out_ff, out_in;

   logic advance;
   logic last_cmd;
   logic load;
   logic [fsd_pkg::POS_W-1:0]        pos;
   logic [fsd_pkg::DIGIT_W-1:0]      value;
   logic [fsd_pkg::FSD_SEGMENTS-1:0] pattern;
   logic                             lit;
   logic                             pol;

   assign advance  = !out_valid_ff || !rsp_stall;
   assign last_cmd = active_ff && (dig_ff == cur_ff.last_idx) && (seg_ff == SEG_LAST);
   assign load     = advance && pop_valid && (!active_ff || last_cmd);
   assign pop_ready = load;

   assign pos     = cur_ff.last_idx - dig_ff;
   assign value   = cur_ff.digits[dig_ff];
   assign pattern = fsd_pkg::seg_pattern(value);
   assign lit     = pattern[seg_ff];
   assign pol     = polarity[pos];

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      active_in    = active_ff;
      cur_in       = cur_ff;
      dig_in       = dig_ff;
      seg_in       = seg_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in          = active_ff;
         out_in.digit_select   = pos;
         out_in.segment_select = seg_ff;
         out_in.drive_level    = ~(lit ^ pol);
         out_in.last_pulse     = last_cmd;
         if (active_ff) begin
            if (seg_ff == SEG_LAST) begin
               seg_in = '0;
               dig_in = dig_ff + 1'b1;
            end else begin
               seg_in = seg_ff + 1'b1;
            end
            if (last_cmd) begin
               active_in = 1'b0;
            end
         end
         if (load) begin
            active_in = 1'b1;
            cur_in    = pop_entry;
            dig_in    = '0;
            seg_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      dig_ff <= dig_in;
      seg_ff <= seg_in;
      out_ff <= out_in;
   end

`ifndef SYNTHESIS
   // The run always ends on the lowest position and the last segment.
   a_last_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.last_pulse) |->
         (rsp_word.digit_select == '0) && (rsp_word.segment_select == SEG_LAST))
      else $error("last word not on position zero, last segment");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop_ready |-> pop_valid)
      else $error("queue popped while empty");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (advance && last_cmd && !load) |=> !active_ff)
      else $error("sequencer still active after its last word");
`endif

endmodule

// File: hdl/flip_segment_digit_sequencer_unit.sv
// Channel | Ports                              | Direction | Handshake
// request | req_valid, req_stall, req_word     | in        | valid / stall
// result  | rsp_valid, rsp_stall, rsp_word     | out       | valid / stall
// control | csr_valid, csr_ready, csr_data     | in        | valid / ready
//
// Each request yields DIGITS*7 result words in number mode and 28 in time mode,
// one word per cycle while the result side does not stall.
// The result port sets the sustained rate of requests.
// The converter works out each request's digits and runs ahead of
// the sequencer through a two-entry queue, so runs follow each other with no gap.
// Reset is synchronous and active high; the polarity register resets to 8.
// A stall on the result side holds the output word and backs up through the queue.
module flip_segment_digit_sequencer_unit #(
   parameter int DIGITS      = fsd_pkg::FSD_DIGITS,
   parameter int QUEUE_DEPTH = fsd_pkg::FSD_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fsd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fsd_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [3:0]            csr_data
);

   logic [3:0] polarity_ff, polarity_in;

   logic                   push_valid;
   logic                   push_ready;
   fsd_pkg::fsd_entry_type push_entry;
   logic                   pop_valid;
   logic                   pop_ready;
   fsd_pkg::fsd_entry_type pop_entry;

   assign csr_ready   = 1'b1;
   assign polarity_in = (csr_valid && csr_ready) ? csr_data : polarity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff <= fsd_pkg::POLARITY_RESET;
      end else begin
         polarity_ff <= polarity_in;
      end
   end

   fsd_front #(
      .DIGITS (DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   fsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   fsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .polarity  (polarity_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
